[hdl/itsc_pkg.sv]
// Package for the infix token syntax checker.
// Holds token kind codes, status codes, the result struct and shared helpers.
// No dependencies.
`timescale 1ns / 1ps

package itsc_pkg;

   // Default width of the open parenthesis counter.
   localparam int DEPTH_BITS_DEF = 8;

   // Field widths of the item channels.
   localparam int KIND_W       = 4;
   localparam int STATUS_W     = 4;
   localparam int DEPTH_LEFT_W = 8;

   localparam logic [DEPTH_LEFT_W-1:0] DEPTH_LEFT_MAX = '1;

   // Token kinds. Codes above KIND_END are never valid.
   localparam logic [KIND_W-1:0] KIND_LIT    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_ID     = 4'd1;
   localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd2;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd3;
   localparam logic [KIND_W-1:0] KIND_NEG    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_PLUS   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_MINUS  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_MUL    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_END    = 4'd8;

   // Status codes reported on the last token of an expression.
   localparam logic [STATUS_W-1:0] STAT_OK            = 4'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY         = 4'd1;
   localparam logic [STATUS_W-1:0] STAT_UNEXP_RPAREN  = 4'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_END_START = 4'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_START     = 4'd4;
   localparam logic [STATUS_W-1:0] STAT_AFTER_LIT     = 4'd5;
   localparam logic [STATUS_W-1:0] STAT_AFTER_ID      = 4'd6;
   localparam logic [STATUS_W-1:0] STAT_AFTER_NEG     = 4'd7;
   localparam logic [STATUS_W-1:0] STAT_AFTER_LPAREN  = 4'd8;
   localparam logic [STATUS_W-1:0] STAT_EMPTY_PARENS  = 4'd9;
   localparam logic [STATUS_W-1:0] STAT_AFTER_RPAREN  = 4'd10;
   localparam logic [STATUS_W-1:0] STAT_AFTER_OP      = 4'd11;
   localparam logic [STATUS_W-1:0] STAT_UNBALANCED    = 4'd12;
   localparam logic [STATUS_W-1:0] STAT_BAD_END       = 4'd13;
   localparam logic [STATUS_W-1:0] STAT_SINGLE        = 4'd14;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW      = 4'd15;

   // One result item.
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [DEPTH_LEFT_W-1:0] depth_left;
   } result_type;

   // True for the binary operators.
   function automatic logic is_binop(logic [KIND_W-1:0] kind);
      return (kind == KIND_PLUS) || (kind == KIND_MINUS) || (kind == KIND_MUL);
   endfunction

endpackage

[hdl/itsc_ifs.sv]
// Valid/ready channel interfaces for the infix token syntax checker.
// Depends on itsc_pkg for the field widths.
`timescale 1ns / 1ps

// Token channel: one token kind per item, with a flag on the last token.
interface itsc_req_if;
   logic                      valid;
   logic                      ready;
   logic [itsc_pkg::KIND_W-1:0] token_kind;
   logic                      is_last;

   modport source (output valid, output token_kind, output is_last, input ready);
   modport sink   (input valid, input token_kind, input is_last, output ready);
endinterface

// Result channel: one status item per expression.
interface itsc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [itsc_pkg::STATUS_W-1:0]     status;
   logic [itsc_pkg::DEPTH_LEFT_W-1:0] depth_left;

   modport source (output valid, output status, output depth_left, input ready);
   modport sink   (input valid, input status, input depth_left, output ready);
endinterface

[hdl/infix_token_syntax_checker_core.sv]
// Top level of the infix token syntax checker: token register, expression
// tracker and result register. Depends on itsc_pkg, itsc_ifs and itsc_tracker.
`timescale 1ns / 1ps

// The block checks the syntax of an infix expression given as a stream of
// token kinds, one token per item, and returns one status item for each
// expression when its last token (is_last high) has been processed. Tokens
// are taken one per clock cycle while the token register is not held: a
// token is registered on acceptance, then processed by the grammar machine and
// depth counter, and for a last token the status is then registered in the
// result register. The token register only waits when it holds a last token
// while an earlier status has not yet been taken, so the rate is one token per
// cycle whenever the result side keeps up. The first error of an expression
// is kept; after a result the block starts afresh.
module infix_token_syntax_checker_core #(
   parameter int DEPTH_BITS = itsc_pkg::DEPTH_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   itsc_req_if.sink   req_item,
   itsc_rsp_if.source rsp_item
);
   import itsc_pkg::*;

   logic              tok_valid_ff, tok_valid_in;
   logic [KIND_W-1:0] tok_kind_ff;
   logic              tok_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   result_type        step_result;
   logic              out_free;
   logic              tok_fire;
   logic              req_take;

   // Handshake control between the token register and the result register.
   assign out_free       = !rsp_valid_ff || rsp_item.ready;
   assign tok_fire       = tok_valid_ff && (!tok_last_ff || out_free);
   assign req_item.ready = !reset && (!tok_valid_ff || tok_fire);
   assign req_take       = req_item.valid && req_item.ready;

   always_comb begin
      tok_valid_in = tok_valid_ff;
      if (req_take) begin
         tok_valid_in = 1'b1;
      end else if (tok_fire) begin
         tok_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tok_fire && tok_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_item.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Expression state and per-token checks.
   itsc_tracker #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (tok_fire),
      .kind   (tok_kind_ff),
      .last   (tok_last_ff),
      .result (step_result)
   );

   // Token register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         tok_kind_ff <= req_item.token_kind;
         tok_last_ff <= req_item.is_last;
      end
      if (tok_fire && tok_last_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_item.valid      = rsp_valid_ff;
   assign rsp_item.status     = rsp_data_ff.status;
   assign rsp_item.depth_left = rsp_data_ff.depth_left;

endmodule

[hdl/itsc_tracker.sv]
// Expression state of the syntax checker: grammar machine, depth counter,
// previous token kind and latched first error. Depends on itsc_pkg.
`timescale 1ns / 1ps

module itsc_tracker #(
   parameter int DEPTH_BITS = itsc_pkg::DEPTH_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [itsc_pkg::KIND_W-1:0] kind,
   input  logic                        last,
   output itsc_pkg::result_type        result
);
   import itsc_pkg::*;

   typedef enum logic [2:0] {
      GS_START  = 3'd0,
      GS_LIT    = 3'd1,
      GS_ID     = 3'd2,
      GS_NEG    = 3'd3,
      GS_LPAREN = 3'd4,
      GS_RPAREN = 3'd5,
      GS_OP     = 3'd6
   } gram_type;

   typedef struct packed {
      gram_type            state;
      logic [STATUS_W-1:0] err;
   } step_type;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
   localparam int WIDE_W = (DEPTH_BITS > DEPTH_LEFT_W) ? DEPTH_BITS : DEPTH_LEFT_W;

   // An operand is expected: literal, identifier, '(' or unary minus.
   function automatic step_type take_operand(logic [KIND_W-1:0] k,
                                             logic [STATUS_W-1:0] code);
      step_type r;
      r.err = STAT_OK;
      if (k == KIND_LIT) begin
         r.state = GS_LIT;
      end else if (k == KIND_ID) begin
         r.state = GS_ID;
      end else if (k == KIND_LPAREN) begin
         r.state = GS_LPAREN;
      end else if (k == KIND_NEG) begin
         r.state = GS_NEG;
      end else begin
         r.state = GS_START;
         r.err   = code;
      end
      return r;
   endfunction

   // Grammar transition for one token; err is nonzero on a syntax error.
   function automatic step_type gram_next(gram_type s, logic [KIND_W-1:0] k);
      step_type r;
      r.state = s;
      r.err   = STAT_OK;
      unique case (s)
         GS_LIT, GS_ID, GS_RPAREN: begin
            if (is_binop(k)) begin
               r.state = GS_OP;
            end else if (k == KIND_RPAREN) begin
               r.state = GS_RPAREN;
            end else if (k != KIND_END) begin
               r.err = (s == GS_LIT) ? STAT_AFTER_LIT :
                       (s == GS_ID)  ? STAT_AFTER_ID  : STAT_AFTER_RPAREN;
            end
         end
         GS_NEG: begin
            if (k == KIND_LIT) begin
               r.state = GS_LIT;
            end else if (k == KIND_LPAREN) begin
               r.state = GS_LPAREN;
            end else if (k == KIND_ID) begin
               r.state = GS_ID;
            end else begin
               r.err = STAT_AFTER_NEG;
            end
         end
         GS_LPAREN: begin
            if (k == KIND_RPAREN) begin
               r.err = STAT_EMPTY_PARENS;
            end else begin
               r = take_operand(k, STAT_AFTER_LPAREN);
            end
         end
         GS_OP: begin
            r = take_operand(k, STAT_AFTER_OP);
         end
         default: begin
            // The start state, and the unused code, which behaves like it.
            if (k == KIND_END) begin
               r.state = GS_START;
            end else begin
               r = take_operand(k, STAT_BAD_START);
            end
         end
      endcase
      return r;
   endfunction

   gram_type              gram_ff, gram_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [KIND_W-1:0]     prev_kind_ff;
   logic                  first_tok_ff;
   logic [STATUS_W-1:0]   err_ff, err_in;
   logic [STATUS_W-1:0]   final_status;
   logic [WIDE_W-1:0]     depth_wide;
   step_type              gram_step;

   // Depth check first, then the grammar check of the same token.
   always_comb begin
      gram_in   = gram_ff;
      depth_in  = depth_ff;
      err_in    = err_ff;
      gram_step = gram_next(gram_ff, kind);
      if (err_ff == STAT_OK) begin
         if (first_tok_ff && (kind == KIND_END)) begin
            err_in = last ? STAT_EMPTY : STAT_BAD_END_START;
         end else begin
            if (kind == KIND_LPAREN) begin
               if (depth_ff == DEPTH_MAX) begin
                  err_in = STAT_OVERFLOW;
               end else begin
                  depth_in = depth_ff + DEPTH_BITS'(1);
               end
            end else if (kind == KIND_RPAREN) begin
               if (depth_ff == '0) begin
                  err_in = STAT_UNEXP_RPAREN;
               end else begin
                  depth_in = depth_ff - DEPTH_BITS'(1);
               end
            end
            if (err_in == STAT_OK) begin
               gram_in = gram_step.state;
               err_in  = gram_step.err;
            end
         end
      end
   end

   // Checks at the end of the expression, only if no error came earlier.
   always_comb begin
      final_status = err_in;
      if (err_in == STAT_OK) begin
         if (depth_in != '0) begin
            final_status = STAT_UNBALANCED;
         end else if (!first_tok_ff) begin
            if (is_binop(prev_kind_ff) || (prev_kind_ff == KIND_NEG) ||
                (prev_kind_ff == KIND_LPAREN)) begin
               final_status = STAT_BAD_END;
            end
         end else if (kind != KIND_END) begin
            final_status = STAT_SINGLE;
         end
      end
   end

   // The reported depth saturates at the width of the result field.
   assign depth_wide        = WIDE_W'(depth_in);
   assign result.status     = final_status;
   assign result.depth_left = (depth_wide > WIDE_W'(DEPTH_LEFT_MAX)) ?
                              DEPTH_LEFT_MAX : depth_wide[DEPTH_LEFT_W-1:0];

   // State registers; the last token returns everything to the reset state.
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         gram_ff      <= GS_START;
         depth_ff     <= '0;
         prev_kind_ff <= KIND_LIT;
         first_tok_ff <= 1'b1;
         err_ff       <= STAT_OK;
      end else if (step) begin
         gram_ff      <= gram_in;
         depth_ff     <= depth_in;
         prev_kind_ff <= kind;
         first_tok_ff <= 1'b0;
         err_ff       <= err_in;
      end
   end

endmodule

[hdl/itsc_checker.sv]
// Port-level checks for the infix token syntax checker, bound to the top level.
// Depends on itsc_pkg and infix_token_syntax_checker_core.
`timescale 1ns / 1ps

module itsc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_is_last,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [itsc_pkg::STATUS_W-1:0]     rsp_status,
   input logic [itsc_pkg::DEPTH_LEFT_W-1:0] rsp_depth_left
);
   import itsc_pkg::*;

   // A stalled result item holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_depth_left))
      else $error("result item changed while stalled");

   // A new result item follows the acceptance of a last token.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_is_last, 2))
      else $error("result item without a last token");

   // A clean expression leaves no open parenthesis.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_OK) |-> (rsp_depth_left == '0))
      else $error("ok status with open parentheses");

   // An unbalanced status always reports open parentheses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_UNBALANCED) |-> (rsp_depth_left != '0))
      else $error("unbalanced status with zero depth");

   // Reset empties the result register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

endmodule

bind infix_token_syntax_checker_core itsc_checker u_itsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_item.valid),
   .req_ready      (req_item.ready),
   .req_is_last    (req_item.is_last),
   .rsp_valid      (rsp_item.valid),
   .rsp_ready      (rsp_item.ready),
   .rsp_status     (rsp_item.status),
   .rsp_depth_left (rsp_item.depth_left)
);
